FILE: rtl/core/scs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and bit helpers for the serial code scrambler.
// Depends on nothing; every other file of the block uses it by scoped names.
package scs_pkg;

  localparam int unsigned Rounds = 26;
  localparam int unsigned WordW = 32;
  localparam int unsigned NibW = 4;
  localparam int unsigned NumNibs = WordW / NibW;
  localparam int unsigned RotAmount = 7;
  localparam int unsigned AddrW = 4;

  // Operation codes of the action field.
  localparam logic ActEncode = 1'b0;
  localparam logic ActDecode = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegKeyOne = 2'd0;
  localparam logic [1:0] RegKeyTwo = 2'd1;
  localparam logic [1:0] RegInitState = 2'd2;
  localparam logic [1:0] RegProdIndex = 2'd3;

  localparam logic [NibW-1:0] Map1 [16] = '{
    4'd9, 4'd3, 4'd8, 4'd14, 4'd11, 4'd7, 4'd0, 4'd12,
    4'd15, 4'd2, 4'd13, 4'd4, 4'd1, 4'd6, 4'd5, 4'd10
  };
  localparam logic [NibW-1:0] Map2 [16] = '{
    4'd12, 4'd7, 4'd0, 4'd8, 4'd15, 4'd10, 4'd3, 4'd1,
    4'd14, 4'd5, 4'd2, 4'd13, 4'd4, 4'd9, 4'd6, 4'd11
  };
  localparam logic [NibW-1:0] Map2Inv [16] = '{
    4'd2, 4'd7, 4'd10, 4'd6, 4'd12, 4'd9, 4'd14, 4'd1,
    4'd3, 4'd13, 4'd5, 4'd15, 4'd0, 4'd11, 4'd8, 4'd4
  };

  // One word in flight between two cells.
  typedef struct packed {
    logic             valid;
    logic             action;
    logic [WordW-1:0] word;
  } beat_t;

  typedef struct packed {
    logic [WordW-1:0] key_one;
    logic [WordW-1:0] key_two;
  } keys_t;

  function automatic logic [WordW-1:0] reverse_word(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int k = 0; k < WordW; k++) begin
      r[k] = v[WordW-1-k];
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] rotl_word(input logic [WordW-1:0] v);
    return {v[WordW-1-RotAmount:0], v[WordW-1:WordW-RotAmount]};
  endfunction

  function automatic logic [WordW-1:0] rotr_word(input logic [WordW-1:0] v);
    return {v[RotAmount-1:0], v[WordW-1:RotAmount]};
  endfunction

endpackage

FILE: rtl/core/scs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the scrambler's input and result beats.
// Depends on scs_pkg for the field widths.
interface scs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [scs_pkg::WordW-1:0] operand_word;

  modport source (output valid, output action, output operand_word, input ready);
  modport sink (input valid, input action, input operand_word, output ready);
endinterface

interface scs_out_if;
  logic                      valid;
  logic                      ready;
  logic [scs_pkg::WordW-1:0] result_word;

  modport source (output valid, output result_word, input ready);
  modport sink (input valid, input result_word, output ready);
endinterface

FILE: rtl/core/scs_round_cell.sv
`timescale 1ns / 1ps
// One round of the whitening network, registered; runs forward for encode
// beats and backward for decode beats. Depends on scs_pkg.
module scs_round_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  scs_pkg::keys_t keys_i,
  input  scs_pkg::beat_t beat_i,
  output scs_pkg::beat_t beat_o
);

  logic                      valid_q;
  logic                      action_q;
  logic [scs_pkg::WordW-1:0] word_q;
  logic [scs_pkg::WordW-1:0] word_d;
  logic [scs_pkg::WordW-1:0] fwd;
  logic [scs_pkg::WordW-1:0] bwd;

  always_comb begin
    fwd = scs_pkg::rotl_word(scs_pkg::reverse_word(beat_i.word ^ keys_i.key_one))
          ^ keys_i.key_two;
    bwd = scs_pkg::reverse_word(scs_pkg::rotr_word(beat_i.word ^ keys_i.key_two))
          ^ keys_i.key_one;
    word_d = (beat_i.action == scs_pkg::ActDecode) ? bwd : fwd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      action_q <= beat_i.action;
      word_q   <= word_d;
    end
  end

  assign beat_o = '{valid: valid_q, action: action_q, word: word_q};

endmodule

FILE: rtl/core/scs_chain_cell.sv
`timescale 1ns / 1ps
// Nibble S-box chain, registered. At the tail of the pipe it chains encode
// beats; at the head it unchains decode beats. Depends on scs_pkg.
module scs_chain_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     tail_i,
  input  logic [scs_pkg::NibW-1:0] seed_i,
  input  scs_pkg::beat_t           beat_i,
  output scs_pkg::beat_t           beat_o
);

  logic                      valid_q;
  logic                      action_q;
  logic [scs_pkg::WordW-1:0] word_q;
  logic [scs_pkg::WordW-1:0] word_d;
  logic [scs_pkg::WordW-1:0] chained;
  logic [scs_pkg::WordW-1:0] unchained;
  logic [scs_pkg::WordW-1:0] prev_code;
  logic [scs_pkg::NibW-1:0]  prev;
  logic [scs_pkg::NibW-1:0]  nib;
  logic [scs_pkg::NibW-1:0]  o;
  logic                      apply;

  // Encode: each nibble depends on the previous output nibble.
  always_comb begin
    prev    = seed_i;
    chained = '0;
    for (int i = 0; i < scs_pkg::NumNibs; i++) begin
      nib = beat_i.word[i*scs_pkg::NibW +: scs_pkg::NibW];
      o   = prev ^ scs_pkg::Map2[nib];
      chained[i*scs_pkg::NibW +: scs_pkg::NibW] = o;
      prev = scs_pkg::Map1[o];
    end
  end

  // Decode: the previous nibble is already known, so the lanes are independent.
  // Lane i of prev_code holds code nibble i-1; lane zero is unused.
  always_comb begin
    prev_code = {beat_i.word[scs_pkg::WordW-scs_pkg::NibW-1:0], seed_i};
    unchained = '0;
    for (int i = 0; i < scs_pkg::NumNibs; i++) begin
      unchained[i*scs_pkg::NibW +: scs_pkg::NibW] = scs_pkg::Map2Inv[
        beat_i.word[i*scs_pkg::NibW +: scs_pkg::NibW] ^
        ((i == 0) ? seed_i
                  : scs_pkg::Map1[prev_code[i*scs_pkg::NibW +: scs_pkg::NibW]])];
    end
  end

  always_comb begin
    apply  = tail_i ? (beat_i.action == scs_pkg::ActEncode)
                    : (beat_i.action == scs_pkg::ActDecode);
    word_d = beat_i.word;
    if (apply) begin
      word_d = tail_i ? chained : unchained;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      action_q <= beat_i.action;
      word_q   <= word_d;
    end
  end

  assign beat_o = '{valid: valid_q, action: action_q, word: word_q};

endmodule

FILE: rtl/core/serial_code_scrambler.sv
`timescale 1ns / 1ps
// Serial code scrambler top level: APB register file, a head chain cell,
// a row of round cells and a tail chain cell. Depends on scs_pkg and scs_if.
//
// Usage: beats on in_chan carry an action (encode or decode) and a 32-bit
// operand; each gives exactly one beat on out_chan with the result word.
// Keys, seed nibble and product index are written over the APB port at
// byte addresses 0, 4, 8 and 12; the user must write them only while no
// beat is in flight, which the block does not enforce. The pipe is one head
// chain cell, one cell per round (26 rounds) and one tail chain cell that is
// also the output register. One beat is accepted per cycle unless the output
// stalls. All cells advance together; when the receiver holds ready low
// while a result waits, the whole row holds and in_chan.ready drops, and
// nothing is lost. Reset zeroes the APB registers and empties the pipe.
module serial_code_scrambler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  scs_in_if.sink                       in_chan,
  scs_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scs_pkg::AddrW-1:0]    paddr,
  input  logic [scs_pkg::WordW-1:0]    pwdata,
  output logic [scs_pkg::WordW-1:0]    prdata,
  output logic                         pready
);

  logic [scs_pkg::WordW-1:0] key_one_q;
  logic [scs_pkg::WordW-1:0] key_two_q;
  logic [scs_pkg::NibW-1:0]  init_state_q;
  logic [scs_pkg::NibW-1:0]  prod_index_q;
  logic                      wr_en;
  logic [1:0]                reg_idx;
  logic [2*scs_pkg::NibW-1:0] seed_prod;
  logic [scs_pkg::NibW-1:0]  seed;
  logic                      en;
  scs_pkg::keys_t            keys;
  scs_pkg::beat_t            in_beat;
  scs_pkg::beat_t            stage [scs_pkg::Rounds+1];
  scs_pkg::beat_t            tail_beat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_one_q    <= '0;
      key_two_q    <= '0;
      init_state_q <= '0;
      prod_index_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        scs_pkg::RegKeyOne:    key_one_q    <= pwdata;
        scs_pkg::RegKeyTwo:    key_two_q    <= pwdata;
        scs_pkg::RegInitState: init_state_q <= pwdata[scs_pkg::NibW-1:0];
        scs_pkg::RegProdIndex: prod_index_q <= pwdata[scs_pkg::NibW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scs_pkg::RegKeyOne:    prdata = key_one_q;
      scs_pkg::RegKeyTwo:    prdata = key_two_q;
      scs_pkg::RegInitState: prdata = {{(scs_pkg::WordW-scs_pkg::NibW){1'b0}}, init_state_q};
      scs_pkg::RegProdIndex: prdata = {{(scs_pkg::WordW-scs_pkg::NibW){1'b0}}, prod_index_q};
      default:               prdata = '0;
    endcase
  end

  assign seed_prod = {{scs_pkg::NibW{1'b0}}, init_state_q} *
                     {{scs_pkg::NibW{1'b0}}, prod_index_q};
  assign seed      = scs_pkg::Map1[seed_prod[scs_pkg::NibW-1:0]];
  assign keys      = '{key_one: key_one_q, key_two: key_two_q};

  // The row moves whenever the output register is free or being drained.
  assign en            = !tail_beat.valid || out_chan.ready;
  assign in_chan.ready = en;
  assign in_beat       = '{valid: in_chan.valid, action: in_chan.action,
                           word: in_chan.operand_word};

  scs_chain_cell u_head (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tail_i (1'b0),
    .seed_i (seed),
    .beat_i (in_beat),
    .beat_o (stage[0])
  );

  for (genvar r = 0; r < scs_pkg::Rounds; r++) begin : g_round
    scs_round_cell u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .keys_i (keys),
      .beat_i (stage[r]),
      .beat_o (stage[r+1])
    );
  end

  scs_chain_cell u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tail_i (1'b1),
    .seed_i (seed),
    .beat_i (stage[scs_pkg::Rounds]),
    .beat_o (tail_beat)
  );

  assign out_chan.valid       = tail_beat.valid;
  assign out_chan.result_word = tail_beat.word;

`ifndef SYNTH
  a_accept_enters_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan.valid && in_chan.ready |=> stage[0].valid)
    else $error("accepted beat did not enter the head cell");

  a_stall_only_on_full_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_chan.ready |-> tail_beat.valid && !out_chan.ready)
    else $error("input stalled without a waiting result");

  a_row_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(stage[scs_pkg::Rounds]) && $stable(tail_beat))
    else $error("pipeline moved during a stall");

  a_last_round_feeds_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && stage[scs_pkg::Rounds].valid |=> out_chan.valid)
    else $error("last round beat did not reach the output register");
`endif

endmodule
